### sv/cfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    // Depth of the tap store and of the delay line.
    localparam int MAX_TAPS = 128;
    localparam int TAP_AW   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    localparam int SMP_W    = 16;
    localparam int IDX_W    = 7;
    localparam int DEC_W    = 5;
    localparam int TAPS_W   = 8;
    localparam int PROD_W   = 2 * SMP_W;
    localparam int ACC_W    = PROD_W + TAP_AW + 1;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int IN_DW    = 56;
    localparam int OUT_DW   = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PUSH = 1'b1
    } t_op;

    typedef enum logic {
        REG_DECIM = 1'b0,
        REG_TAPS  = 1'b1
    } t_reg;

    typedef struct packed {
        logic wr_tap;
        logic wr_smp;
        logic start;
        logic issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic drained;
    } t_status;

    // A zero tap count acts as one; counts above the store depth are clamped.
    function automatic logic [CNT_W-1:0] eff_taps(input logic [TAPS_W-1:0] t);
        logic [TAPS_W-1:0] v;
        v = (t == '0) ? TAPS_W'(1) : t;
        if (int'(v) > MAX_TAPS) begin
            return CNT_W'(MAX_TAPS);
        end
        return CNT_W'(v);
    endfunction

    // A zero decimation factor acts as one.
    function automatic logic [DEC_W-1:0] eff_dec(input logic [DEC_W-1:0] d);
        return (d == '0) ? DEC_W'(1) : d;
    endfunction

endpackage

`default_nettype wire

### sv/cfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/cfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cfd_ctrl
    import cfd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_op              i_op,
    input  wire logic [DEC_W-1:0] i_dec,
    input  wire logic             i_out_free,
    input  wire t_status          i_status,
    output logic                  o_in_ready,
    output t_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAC   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [DEC_W-1:0] r_phase, n_phase;
    logic             accept;
    logic             fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign fire       = (r_phase <= DEC_W'(1));

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_tap   = accept && (i_op == OP_LOAD);
        o_cmd.wr_smp   = accept && (i_op == OP_PUSH);
        o_cmd.start    = o_cmd.wr_smp && fire;
        o_cmd.issue    = (r_state == S_MAC);
        o_cmd.load_out = (r_state == S_FLUSH) && i_status.drained && i_out_free;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        if (o_cmd.wr_smp) begin
            n_phase = fire ? eff_dec(i_dec) : (r_phase - DEC_W'(1));
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (i_status.last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= DEC_W'(1);
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

### sv/cfd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module cfd_dpath
    import cfd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire logic        [CNT_W-1:0] i_taps,
    input  wire logic        [IDX_W-1:0] i_coef_index,
    input  wire logic signed [SMP_W-1:0] i_coef_value,
    input  wire logic signed [SMP_W-1:0] i_sample_re,
    input  wire logic signed [SMP_W-1:0] i_sample_im,
    output t_status                      o_status,
    output logic signed      [SMP_W-1:0] o_out_re,
    output logic signed      [SMP_W-1:0] o_out_im
);

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (SMP_W - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

    logic [TAP_AW-1:0]        r_wp, wp_new;
    logic [TAP_AW-1:0]        r_n, r_idx;
    logic [CNT_W-1:0]         idx_inc;
    logic [MAX_TAPS-1:0]      r_dvalid;
    logic                     r_v1, r_v2, r_dv;
    logic                     tap_we;
    logic [SMP_W-1:0]         tap_q;
    logic [2*SMP_W-1:0]       dly_q;
    logic signed [SMP_W-1:0]  d_re, d_im;
    logic signed [PROD_W-1:0] r_p_re, r_p_im;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;

    // Pointer moves down, wrapping to the top of the active line.
    always_comb begin
        if (r_wp == '0 || CNT_W'(r_wp) >= i_taps) begin
            wp_new = TAP_AW'(i_taps - CNT_W'(1));
        end else begin
            wp_new = r_wp - TAP_AW'(1);
        end
    end

    assign tap_we  = i_cmd.wr_tap && (int'(i_coef_index) < MAX_TAPS);
    assign idx_inc = CNT_W'(r_idx) + CNT_W'(1);

    cfd_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (TAP_AW'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_n),
        .o_rdata (tap_q)
    );

    cfd_ram #(.WIDTH(2 * SMP_W), .DEPTH(MAX_TAPS)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_smp),
        .i_waddr (wp_new),
        .i_wdata ({i_sample_im, i_sample_re}),
        .i_re    (i_cmd.issue),
        .i_raddr (r_idx),
        .o_rdata (dly_q)
    );

    // Slots never written since reset read as zero.
    assign d_re = r_dv ? signed'(dly_q[SMP_W-1:0])       : '0;
    assign d_im = r_dv ? signed'(dly_q[2*SMP_W-1:SMP_W]) : '0;

    assign o_status.last    = (CNT_W'(r_n) == (i_taps - CNT_W'(1)));
    assign o_status.drained = !r_v1 && !r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_dvalid <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cmd.wr_smp) begin
                r_wp             <= wp_new;
                r_dvalid[wp_new] <= 1'b1;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n      <= '0;
            r_idx    <= wp_new;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_n   <= r_n + TAP_AW'(1);
                r_idx <= (idx_inc == i_taps) ? '0 : TAP_AW'(idx_inc);
                r_dv  <= r_dvalid[r_idx];
            end
            if (r_v2) begin
                r_acc_re <= r_acc_re + ACC_W'(r_p_re);
                r_acc_im <= r_acc_im + ACC_W'(r_p_im);
            end
        end
        r_p_re <= signed'(tap_q) * d_re;
        r_p_im <= signed'(tap_q) * d_im;
    end

    function automatic logic signed [SMP_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] s;
        s = (acc + RND_BIAS) >>> (SMP_W - 1);
        if (s > SAT_HI) begin
            return SAT_HI[SMP_W-1:0];
        end
        if (s < SAT_LO) begin
            return SAT_LO[SMP_W-1:0];
        end
        return s[SMP_W-1:0];
    endfunction

    assign o_out_re = round_sat(r_acc_re);
    assign o_out_im = round_sat(r_acc_im);

endmodule

`default_nettype wire

### sv/complex_fir_decimator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                      Payload
// s_axis       in         s_axis_tvalid / s_axis_tready  tuser: operation; tdata: coef and sample
// m_axis       out        m_axis_tvalid / m_axis_tready  tdata: out_re, out_im
// APB config   in         psel, penable, pwrite, pready  decimation_factor at 0x0, taps at 0x4
//
// A coefficient load, or a sample push that does not complete a decimation phase, leaves
// s_axis_tready high. A push that completes a phase holds s_axis_tready low while M taps are
// processed, where M is the effective tap count: one shared multiply-accumulate per rail takes
// one tap and one delay slot per cycle, then the read and multiplier stages drain and the result
// is loaded. Reset is synchronous and active low; per-slot valid bits make the delay line read
// as zero. A waiting result stalls that load, and so the input, until the output register is free.

module complex_fir_decimator
    import cfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input items.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: coef_index[6:0], coef_value[22:7], sample_re[38:23],
    // sample_im[54:39], zero fill [55].
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // tuser: operation (0 = load coefficient, 1 = push sample).
    input  wire logic              s_axis_tuser,
    // Result items.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // tdata from bit 0: out_re[15:0], out_im[31:16].
    output logic [OUT_DW-1:0]      m_axis_tdata,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [DEC_W-1:0]        r_decim;
    logic [TAPS_W-1:0]       r_taps;
    logic                    r_out_valid;
    logic [OUT_DW-1:0]       r_out_data;
    logic                    cfg_wr;
    t_reg                    reg_sel;
    t_cmd                    cmd;
    t_status                 status;
    logic                    out_free;
    logic signed [SMP_W-1:0] res_re, res_im;

    // The register is chosen by the word address; byte offsets within a word are ignored.
    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_DECIM: prdata = APB_DW'(r_decim);
            REG_TAPS:  prdata = APB_DW'(r_taps);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= DEC_W'(2);
            r_taps  <= TAPS_W'(100);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_DECIM: r_decim <= pwdata[DEC_W-1:0];
                REG_TAPS:  r_taps  <= pwdata[TAPS_W-1:0];
                default:   ;
            endcase
        end
    end

    // The output register frees up in the same cycle that its item is taken.
    assign out_free = !r_out_valid || m_axis_tready;

    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (t_op'(s_axis_tuser)),
        .i_dec      (r_decim),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cfd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_taps       (eff_taps(r_taps)),
        .i_coef_index (s_axis_tdata[6:0]),
        .i_coef_value (s_axis_tdata[22:7]),
        .i_sample_re  (s_axis_tdata[38:23]),
        .i_sample_im  (s_axis_tdata[54:39]),
        .o_status     (status),
        .o_out_re     (res_re),
        .o_out_im     (res_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_data <= {res_im, res_re};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
